[rtl/rvex_pkg.sv]
// Shared types, opcode codes and ALU helper for the RV64I execute unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rvex_pkg;

  localparam logic [5:0] OP_ADD   = 6'd0;
  localparam logic [5:0] OP_SUB   = 6'd1;
  localparam logic [5:0] OP_SLTU  = 6'd9;
  localparam logic [5:0] OP_ADDI  = 6'd10;
  localparam logic [5:0] OP_SLTIU = 6'd18;
  localparam logic [5:0] OP_LD    = 6'd19;
  localparam logic [5:0] OP_LW    = 6'd20;
  localparam logic [5:0] OP_LH    = 6'd21;
  localparam logic [5:0] OP_LB    = 6'd22;
  localparam logic [5:0] OP_LHU   = 6'd23;
  localparam logic [5:0] OP_LBU   = 6'd24;
  localparam logic [5:0] OP_LWU   = 6'd25;
  localparam logic [5:0] OP_JALR  = 6'd26;
  localparam logic [5:0] OP_SD    = 6'd27;
  localparam logic [5:0] OP_SW    = 6'd28;
  localparam logic [5:0] OP_SH    = 6'd29;
  localparam logic [5:0] OP_SB    = 6'd30;
  localparam logic [5:0] OP_BEQ   = 6'd31;
  localparam logic [5:0] OP_BNE   = 6'd32;
  localparam logic [5:0] OP_BLT   = 6'd33;
  localparam logic [5:0] OP_BGE   = 6'd34;
  localparam logic [5:0] OP_BLTU  = 6'd35;
  localparam logic [5:0] OP_BGEU  = 6'd36;
  localparam logic [5:0] OP_JAL   = 6'd37;
  localparam logic [5:0] OP_LUI   = 6'd38;
  localparam logic [5:0] OP_AUIPC = 6'd39;

  localparam logic [3:0] ALU_ADD  = 4'd0;
  localparam logic [3:0] ALU_SUB  = 4'd1;
  localparam logic [3:0] ALU_AND  = 4'd2;
  localparam logic [3:0] ALU_OR   = 4'd3;
  localparam logic [3:0] ALU_XOR  = 4'd4;
  localparam logic [3:0] ALU_SLL  = 4'd5;
  localparam logic [3:0] ALU_SRL  = 4'd6;
  localparam logic [3:0] ALU_SRA  = 4'd7;
  localparam logic [3:0] ALU_SLT  = 4'd8;

  typedef struct packed {
    logic [5:0]         opcode;
    logic [4:0]         dest_index;
    logic [4:0]         src_a_index;
    logic [4:0]         src_b_index;
    logic signed [31:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        next_pc;
    logic               reg_written;
    logic [4:0]         written_index;
    logic signed [63:0] written_value;
    logic               out_of_bounds;
  } out_item_t;

  typedef struct packed {
    logic        we;
    logic [4:0]  addr;
    logic [63:0] data;
  } rf_wr_t;

  function automatic logic [63:0] alu(input logic [3:0] op, input logic [63:0] a,
                                      input logic [63:0] b);
    logic [5:0] s;
    s = b[5:0];
    case (op)
      ALU_ADD: alu = a + b;
      ALU_SUB: alu = a - b;
      ALU_AND: alu = a & b;
      ALU_OR:  alu = a | b;
      ALU_XOR: alu = a ^ b;
      ALU_SLL: alu = a << s;
      ALU_SRL: alu = a >> s;
      ALU_SRA: alu = $unsigned($signed(a) >>> s);
      ALU_SLT: alu = {63'b0, $signed(a) < $signed(b)};
      default: alu = {63'b0, a < b};
    endcase
  endfunction

endpackage
`default_nettype wire

[rtl/rvex_regfile.sv]
// 32 x 64 register file, two synchronous read ports, one write port.
// Duplicated storage per read port; reset valid bits make unwritten entries read zero.
`timescale 1ns / 1ps
`default_nettype none
module rvex_regfile (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rvex_pkg::rf_wr_t wr,
  input  wire logic            re,
  input  wire logic [4:0]      raddr_a,
  input  wire logic [4:0]      raddr_b,
  output logic [63:0]          rdata_a,
  output logic [63:0]          rdata_b
);
  import rvex_pkg::*;

  logic [63:0] mem_a [32];
  logic [63:0] mem_b [32];
  logic [31:0] vld_r;
  logic [63:0] rda_r, rdb_r;
  logic        va_r, vb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.we) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_a[wr.addr] <= wr.data;
      mem_b[wr.addr] <= wr.data;
    end
    if (re) begin
      rda_r <= mem_a[raddr_a];
      rdb_r <= mem_b[raddr_b];
      va_r  <= vld_r[raddr_a];
      vb_r  <= vld_r[raddr_b];
    end
  end

  assign rdata_a = va_r ? rda_r : 64'd0;
  assign rdata_b = vb_r ? rdb_r : 64'd0;

endmodule
`default_nettype wire

[rtl/rvex_bank.sv]
// One bank of data memory: rows of eight bytes, byte-enable write, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module rvex_bank #(
  parameter int ROWS = 256,
  parameter int AW   = 8
) (
  input  wire logic          clk,
  input  wire logic [7:0]    wbe,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [63:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [63:0]        rdata
);
  logic [7:0][7:0] mem [ROWS];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) begin
      if (wbe[k]) begin
        mem[waddr][k] <= wdata[8*k +: 8];
      end
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/rv64i_integer_execute_unit.sv]
// RV64I execute unit top: two pipeline stages around the register file and a
// two-bank byte memory. Uses rvex_pkg, rvex_regfile, rvex_bank.
//
//   channel | dir | handshake         | payload
//   in      | in  | in_valid/in_stall | in_data  (rvex_pkg::in_item_t)
//   out     | out | out_valid/out_stall | out_data (rvex_pkg::out_item_t)
//
// One item per cycle when not stalled; each result passes stage 1, stage 2, out reg.
// The transfer edge reads the register file; stage 1 executes and issues the memory
// access; stage 2 aligns load data, writes back and loads the output register.
// After reset a clearing pass zeroes all (MEM_BYTES+15)/16 rows of both banks
// (256 at the default) with in_stall high.
// A stalled output register freezes the whole pipeline.
`timescale 1ns / 1ps
`default_nettype none
module rv64i_integer_execute_unit #(
  parameter int MEM_BYTES = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rvex_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rvex_pkg::out_item_t      out_data
);
  import rvex_pkg::*;

  localparam int BANK_ROWS = (MEM_BYTES + 15) / 16;
  localparam int BA_W      = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;
  localparam logic [63:0] MEM_LIM = 64'(MEM_BYTES);

  logic adv, in_fire;
  logic clr_busy_r;
  logic [BA_W:0] clr_cnt_r;

  // stage 1
  logic       s1_v_r;
  logic [5:0] s1_op_r;
  logic [4:0] s1_rd_r, s1_rs1_r, s1_rs2_r;
  logic [31:0] s1_imm_r;
  logic [63:0] pc_r;
  logic [63:0] rf_a, rf_b, opa, opb;

  // stage 2
  logic        s2_v_r, s2_wr_r, s2_ld_r, s2_sgn_r, s2_flt_r, s2_par_r;
  logic [4:0]  s2_rd_r;
  logic [63:0] s2_val_r, s2_npc_r;
  logic [3:0]  s2_sz_r;
  logic [2:0]  s2_off_r;
  logic [63:0] s2_wval;

  logic        lw_v_r;
  logic [4:0]  lw_idx_r;
  logic [63:0] lw_val_r;

  logic        out_valid_r;
  out_item_t   out_data_r;

  // stage 1 decode results
  logic [63:0] imm64, addr, npc, val, up;
  logic        wr, fault, is_ld, is_st, ld_sgn, take;
  logic [3:0]  sz, aop;
  logic [7:0]  bmask;
  logic [BA_W:0]   row;
  logic [BA_W+1:0] rowp1;
  logic [127:0] st_win;
  logic [15:0]  st_en;
  logic [7:0]   be0, be1;
  logic [63:0]  wd0, wd1, rd0, rd1;
  logic [BA_W-1:0] ix0, ix1, wix0, wix1;

  // stage 2 load alignment
  logic [127:0] ld_win;
  logic [63:0]  ld_raw, ld_val;

  rf_wr_t rf_wr;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv || clr_busy_r;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == (BA_W+1)'(BANK_ROWS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign rf_wr.we   = adv && s2_v_r && s2_wr_r;
  assign rf_wr.addr = s2_rd_r;
  assign rf_wr.data = s2_wval;

  rvex_regfile u_rf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (rf_wr),
    .re      (in_fire),
    .raddr_a (in_data.src_a_index),
    .raddr_b (in_data.src_b_index),
    .rdata_a (rf_a),
    .rdata_b (rf_b)
  );

  always_comb begin
    if (s2_v_r && s2_wr_r && s2_rd_r == s1_rs1_r) opa = s2_wval;
    else if (lw_v_r && lw_idx_r == s1_rs1_r)       opa = lw_val_r;
    else                                           opa = rf_a;
    if (s2_v_r && s2_wr_r && s2_rd_r == s1_rs2_r) opb = s2_wval;
    else if (lw_v_r && lw_idx_r == s1_rs2_r)       opb = lw_val_r;
    else                                           opb = rf_b;
  end

  assign imm64 = {{32{s1_imm_r[31]}}, s1_imm_r};
  assign addr  = opa + imm64;
  assign up    = {{32{s1_imm_r[19]}}, s1_imm_r[19:0], 12'b0};
  assign aop   = (s1_op_r == OP_ADDI) ? ALU_ADD : 4'(s1_op_r - 6'd9);

  always_comb begin
    npc    = pc_r + 64'd4;
    val    = '0;
    wr     = 1'b0;
    is_ld  = 1'b0;
    is_st  = 1'b0;
    ld_sgn = 1'b0;
    sz     = 4'd8;
    take   = 1'b0;
    unique case (s1_op_r) inside
      [OP_ADD:OP_SLTU]: begin
        val = alu(s1_op_r[3:0], opa, opb);
        wr  = 1'b1;
      end
      [OP_ADDI:OP_SLTIU]: begin
        val = alu(aop, opa, imm64);
        wr  = 1'b1;
      end
      [OP_LD:OP_LWU]: begin
        is_ld = 1'b1;
        wr    = 1'b1;
        unique case (s1_op_r) inside
          OP_LD:         sz = 4'd8;
          OP_LW, OP_LWU: sz = 4'd4;
          OP_LH, OP_LHU: sz = 4'd2;
          default:       sz = 4'd1;
        endcase
        ld_sgn = (s1_op_r == OP_LW) || (s1_op_r == OP_LH) || (s1_op_r == OP_LB);
      end
      OP_JALR: begin
        val = pc_r + 64'd4;
        npc = {addr[63:1], 1'b0};
        wr  = 1'b1;
      end
      [OP_SD:OP_SB]: begin
        is_st = 1'b1;
        unique case (s1_op_r)
          OP_SD:   sz = 4'd8;
          OP_SW:   sz = 4'd4;
          OP_SH:   sz = 4'd2;
          default: sz = 4'd1;
        endcase
      end
      [OP_BEQ:OP_BGEU]: begin
        unique case (s1_op_r)
          OP_BEQ:  take = (opa == opb);
          OP_BNE:  take = (opa != opb);
          OP_BLT:  take = $signed(opa) < $signed(opb);
          OP_BGE:  take = !($signed(opa) < $signed(opb));
          OP_BLTU: take = opa < opb;
          default: take = !(opa < opb);
        endcase
        if (take) npc = pc_r + imm64;
      end
      OP_JAL: begin
        val = pc_r + 64'd4;
        npc = pc_r + imm64;
        wr  = 1'b1;
      end
      OP_LUI: begin
        val = up;
        wr  = 1'b1;
      end
      OP_AUIPC: begin
        val = pc_r + up;
        wr  = 1'b1;
      end
      default: ;
    endcase
    fault = (is_ld || is_st) && (addr > MEM_LIM - 64'(sz));
    if (fault) begin
      npc = pc_r;
      wr  = 1'b0;
    end
    if (s1_rd_r == 5'd0) wr = 1'b0;
  end

  always_comb begin
    case (sz)
      4'd8:    bmask = 8'hff;
      4'd4:    bmask = 8'h0f;
      4'd2:    bmask = 8'h03;
      default: bmask = 8'h01;
    endcase
  end

  assign row    = addr[BA_W+3:3];
  assign rowp1  = {1'b0, row} + 1'b1;
  assign ix0    = rowp1[BA_W:1];
  assign ix1    = row[BA_W:1];
  assign st_win = {64'd0, opb} << {addr[2:0], 3'b000};
  assign st_en  = (is_st && !fault && s1_v_r && adv) ? ({8'd0, bmask} << addr[2:0]) : 16'd0;

  always_comb begin
    if (clr_busy_r) begin
      wix0 = clr_cnt_r[BA_W-1:0];
      wix1 = clr_cnt_r[BA_W-1:0];
      be0  = 8'hff;
      be1  = 8'hff;
      wd0  = '0;
      wd1  = '0;
    end else begin
      wix0 = ix0;
      wix1 = ix1;
      be0  = row[0] ? st_en[15:8]    : st_en[7:0];
      be1  = row[0] ? st_en[7:0]     : st_en[15:8];
      wd0  = row[0] ? st_win[127:64] : st_win[63:0];
      wd1  = row[0] ? st_win[63:0]   : st_win[127:64];
    end
  end

  rvex_bank #(.ROWS(BANK_ROWS), .AW(BA_W)) u_bank0 (
    .clk (clk), .wbe (be0), .waddr (wix0), .wdata (wd0),
    .re (adv), .raddr (ix0), .rdata (rd0)
  );

  rvex_bank #(.ROWS(BANK_ROWS), .AW(BA_W)) u_bank1 (
    .clk (clk), .wbe (be1), .waddr (wix1), .wdata (wd1),
    .re (adv), .raddr (ix1), .rdata (rd1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      lw_v_r <= 1'b0;
      pc_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= in_fire;
      s2_v_r      <= s1_v_r;
      out_valid_r <= s2_v_r;
      if (s1_v_r) pc_r <= npc;
      if (rf_wr.we) lw_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r  <= in_data.opcode;
      s1_rd_r  <= in_data.dest_index;
      s1_rs1_r <= in_data.src_a_index;
      s1_rs2_r <= in_data.src_b_index;
      s1_imm_r <= in_data.immediate;
    end
    if (adv) begin
      s2_wr_r  <= wr;
      s2_rd_r  <= s1_rd_r;
      s2_val_r <= val;
      s2_npc_r <= npc;
      s2_ld_r  <= is_ld;
      s2_sgn_r <= ld_sgn;
      s2_flt_r <= fault;
      s2_sz_r  <= sz;
      s2_off_r <= addr[2:0];
      s2_par_r <= row[0];
      if (rf_wr.we) begin
        lw_idx_r <= s2_rd_r;
        lw_val_r <= s2_wval;
      end
      out_data_r.next_pc       <= s2_npc_r;
      out_data_r.reg_written   <= s2_wr_r;
      out_data_r.written_index <= s2_wr_r ? s2_rd_r : 5'd0;
      out_data_r.written_value <= s2_wr_r ? s2_wval : 64'd0;
      out_data_r.out_of_bounds <= s2_flt_r;
    end
  end

  assign ld_win = s2_par_r ? {rd0, rd1} : {rd1, rd0};
  assign ld_raw = 64'(ld_win >> {s2_off_r, 3'b000});

  always_comb begin
    case (s2_sz_r)
      4'd4:    ld_val = s2_sgn_r ? {{32{ld_raw[31]}}, ld_raw[31:0]} : {32'd0, ld_raw[31:0]};
      4'd2:    ld_val = s2_sgn_r ? {{48{ld_raw[15]}}, ld_raw[15:0]} : {48'd0, ld_raw[15:0]};
      4'd1:    ld_val = s2_sgn_r ? {{56{ld_raw[7]}}, ld_raw[7:0]} : {56'd0, ld_raw[7:0]};
      default: ld_val = ld_raw;
    endcase
  end

  assign s2_wval   = s2_ld_r ? ld_val : s2_val_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s2_flt_r) |-> !s2_wr_r)
    else $error("faulting access marked as register write");

  a_fault_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_v_r && fault) |=> (pc_r == $past(pc_r)))
    else $error("pc moved on faulting access");

  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_wr.we |-> (rf_wr.addr != 5'd0))
    else $error("write to x0");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!s1_v_r && !s2_v_r && !out_valid_r))
    else $error("pipeline active during memory clear");

endmodule
`default_nettype wire

[tb/rv64i_integer_execute_unit_tb.sv]
// Testbench for rv64i_integer_execute_unit: random and directed RV64I instructions,
// predicted by an in-bench architectural model and checked transfer by transfer.
// Depends on rvex_pkg and the execute unit RTL.
`timescale 1ns / 1ps
module rv64i_integer_execute_unit_tb;
  import rvex_pkg::*;

  localparam int MEM_SIZE = 4096;
  localparam logic [5:0] OP_SLL  = 6'd5;
  localparam logic [5:0] OP_SRA  = 6'd7;
  localparam logic [5:0] OP_SLT  = 6'd8;
  localparam logic [5:0] OP_SRAI = 6'd16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  rv64i_integer_execute_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  logic [63:0] arch_regs [32];
  logic [7:0] arch_mem [MEM_SIZE];
  logic [63:0] arch_pc;
  in_item_t pending_instrs [$];
  out_item_t expected_results [$];
  int errors = 0;
  bit in_acc = 1'b0;

  function automatic logic [63:0] alu_ref(logic [3:0] op, logic [63:0] a, logic [63:0] b);
    logic [5:0] s;
    s = b[5:0];
    case (op)
      ALU_ADD: return a + b;
      ALU_SUB: return a - b;
      ALU_AND: return a & b;
      ALU_OR:  return a | b;
      ALU_XOR: return a ^ b;
      ALU_SLL: return a << s;
      ALU_SRL: return a >> s;
      ALU_SRA: return $unsigned($signed(a) >>> s);
      ALU_SLT: return {63'b0, $signed(a) < $signed(b)};
      default: return {63'b0, a < b};
    endcase
  endfunction

  function automatic void execute_instr(in_item_t it);
    out_item_t r;
    logic [63:0] a, b, imm, pc, npc, val, addr, up;
    logic wr, fault, take;
    int sz;
    a = arch_regs[it.src_a_index];
    b = arch_regs[it.src_b_index];
    imm = {{32{it.immediate[31]}}, it.immediate};
    pc = arch_pc;
    npc = pc + 64'd4;
    val = '0;
    wr = 1'b0;
    fault = 1'b0;
    take = 1'b0;
    if (it.opcode <= OP_SLTU) begin
      val = alu_ref(it.opcode[3:0], a, b);
      wr = 1'b1;
    end else if (it.opcode <= OP_SLTIU) begin
      val = alu_ref((it.opcode == OP_ADDI) ? ALU_ADD : 4'(it.opcode - OP_ADDI + 1), a, imm);
      wr = 1'b1;
    end else if (it.opcode <= OP_LWU) begin
      addr = a + imm;
      case (it.opcode)
        OP_LD: sz = 8;
        OP_LW, OP_LWU: sz = 4;
        OP_LH, OP_LHU: sz = 2;
        default: sz = 1;
      endcase
      if (addr > 64'(MEM_SIZE - sz)) fault = 1'b1;
      else begin
        for (int i = 0; i < sz; i++) val[8*i +: 8] = arch_mem[addr + i];
        case (it.opcode)
          OP_LW: val = {{32{val[31]}}, val[31:0]};
          OP_LH: val = {{48{val[15]}}, val[15:0]};
          OP_LB: val = {{56{val[7]}}, val[7:0]};
          default: ;
        endcase
        wr = 1'b1;
      end
    end else if (it.opcode == OP_JALR) begin
      val = pc + 64'd4;
      npc = (a + imm) & ~64'd1;
      wr = 1'b1;
    end else if (it.opcode <= OP_SB) begin
      addr = a + imm;
      case (it.opcode)
        OP_SD: sz = 8;
        OP_SW: sz = 4;
        OP_SH: sz = 2;
        default: sz = 1;
      endcase
      if (addr > 64'(MEM_SIZE - sz)) fault = 1'b1;
      else for (int i = 0; i < sz; i++) arch_mem[addr + i] = b[8*i +: 8];
    end else if (it.opcode <= OP_BGEU) begin
      case (it.opcode)
        OP_BEQ: take = (a == b);
        OP_BNE: take = (a != b);
        OP_BLT: take = $signed(a) < $signed(b);
        OP_BGE: take = !($signed(a) < $signed(b));
        OP_BLTU: take = a < b;
        default: take = !(a < b);
      endcase
      if (take) npc = pc + imm;
    end else if (it.opcode == OP_JAL) begin
      val = pc + 64'd4;
      npc = pc + imm;
      wr = 1'b1;
    end else if (it.opcode == OP_LUI || it.opcode == OP_AUIPC) begin
      up = {{32{it.immediate[19]}}, it.immediate[19:0], 12'b0};
      val = (it.opcode == OP_LUI) ? up : pc + up;
      wr = 1'b1;
    end
    if (fault) begin
      npc = pc;
      wr = 1'b0;
    end
    if (it.dest_index == 5'd0) wr = 1'b0;
    if (wr) arch_regs[it.dest_index] = val;
    else val = '0;
    arch_pc = npc;
    r.next_pc = npc;
    r.reg_written = wr;
    r.written_index = wr ? it.dest_index : 5'd0;
    r.written_value = val;
    r.out_of_bounds = fault;
    expected_results = {expected_results, r};
  endfunction

  function automatic void add_pending(in_item_t it);
    pending_instrs = {pending_instrs, it};
  endfunction

  function automatic in_item_t make_instr(logic [5:0] op, int rd, int ra, int rb, int imm);
    in_item_t it;
    it.opcode = op;
    it.dest_index = 5'(rd);
    it.src_a_index = 5'(ra);
    it.src_b_index = 5'(rb);
    it.immediate = imm;
    return it;
  endfunction

  // mostly offsets from -4 to MEM_SIZE+4 so most loads and stores land in memory; base reg is x0
  function automatic in_item_t rand_instr();
    in_item_t it;
    int k;
    it = '0;
    it.dest_index = 5'($urandom_range(0, 31));
    it.src_a_index = 5'($urandom_range(0, 31));
    it.src_b_index = 5'($urandom_range(0, 31));
    it.immediate = $urandom;
    k = $urandom_range(0, 99);
    if (k < 30) it.opcode = 6'($urandom_range(0, 18));
    else if (k < 60) begin
      it.opcode = 6'($urandom_range(OP_LD, OP_SB));
      if (it.opcode == OP_JALR) it.opcode = OP_SD;
      it.src_a_index = 5'd0;
      it.immediate = (k < 57) ? $urandom_range(0, MEM_SIZE + 8) - 4 : $urandom;
    end else if (k < 75) begin
      it.opcode = 6'($urandom_range(OP_BEQ, OP_BGEU));
      if ($urandom_range(0, 3) != 0) it.immediate = $urandom_range(0, 64) - 32;
    end else if (k < 80) it.opcode = OP_JAL;
    else if (k < 83) it.opcode = OP_JALR;
    else if (k < 93) it.opcode = 6'($urandom_range(OP_LUI, OP_AUIPC));
    else if (k < 97) it.opcode = 6'($urandom_range(40, 63));
    else it.opcode = 6'($urandom_range(0, 63));
    return it;
  endfunction

  initial begin
    add_pending(make_instr(OP_ADDI, 1, 0, 0, -1));
    add_pending(make_instr(OP_ADDI, 2, 0, 0, 32'h7fffffff));
    add_pending(make_instr(OP_LUI, 3, 0, 0, 32'hfff80000));
    add_pending(make_instr(OP_ADDI, 0, 1, 0, 5));
    add_pending(make_instr(OP_SD, 0, 0, 1, MEM_SIZE - 8));
    add_pending(make_instr(OP_SD, 0, 0, 1, MEM_SIZE - 7));
    add_pending(make_instr(OP_LB, 4, 0, 0, MEM_SIZE - 1));
    add_pending(make_instr(OP_LBU, 5, 0, 0, MEM_SIZE - 1));
    add_pending(make_instr(OP_LH, 6, 0, 0, MEM_SIZE - 2));
    add_pending(make_instr(OP_LHU, 7, 0, 0, MEM_SIZE - 2));
    add_pending(make_instr(OP_LW, 8, 0, 0, MEM_SIZE - 4));
    add_pending(make_instr(OP_LWU, 9, 0, 0, MEM_SIZE - 4));
    add_pending(make_instr(OP_LD, 10, 1, 0, 0));
    add_pending(make_instr(OP_SRAI, 11, 1, 0, 32'h7f));
    add_pending(make_instr(OP_SLL, 12, 2, 1, 0));
    add_pending(make_instr(OP_SRA, 13, 3, 2, 0));
    add_pending(make_instr(OP_SLTU, 14, 0, 1, 0));
    add_pending(make_instr(OP_SLT, 15, 1, 0, 0));
    add_pending(make_instr(OP_BLT, 0, 1, 0, -8));
    add_pending(make_instr(OP_BGEU, 0, 1, 0, 32'h80000000));
    add_pending(make_instr(OP_JALR, 2, 2, 0, 3));
    add_pending(make_instr(OP_JAL, 16, 0, 0, -4));
    add_pending(make_instr(OP_AUIPC, 17, 0, 0, 32'h000fffff));
    add_pending(make_instr(OP_SB, 0, 0, 2, 0));
    add_pending(make_instr(6'd63, 1, 1, 1, 0));
    for (int n = 0; n < 650; n++) add_pending(rand_instr());
  end

  initial begin
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
    for (int i = 0; i < MEM_SIZE; i++) arch_mem[i] = '0;
    arch_pc = '0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  int cyc = 0;
  always @(posedge clk) cyc <= cyc + 1;
  wire calm = (cyc > 450 && cyc < 750);

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_acc) begin
        if (pending_instrs.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
          in_data <= pending_instrs.pop_front();
          in_valid <= 1'b1;
        end else in_valid <= 1'b0;
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 8);
    end
  end

  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) execute_instr(in_data);
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected transfer: %h", out_data);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.next_pc !== e.next_pc) begin
          $error("next_pc exp %h got %h", e.next_pc, out_data.next_pc); errors++;
        end
        if (out_data.reg_written !== e.reg_written) begin
          $error("reg_written exp %b got %b", e.reg_written, out_data.reg_written); errors++;
        end
        if (out_data.written_index !== e.written_index) begin
          $error("written_index exp %0d got %0d", e.written_index, out_data.written_index);
          errors++;
        end
        if (out_data.written_value !== e.written_value) begin
          $error("written_value exp %h got %h", e.written_value, out_data.written_value);
          errors++;
        end
        if (out_data.out_of_bounds !== e.out_of_bounds) begin
          $error("out_of_bounds exp %b got %b", e.out_of_bounds, out_data.out_of_bounds);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (rst_n);
    wait (pending_instrs.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("** rv64i_integer_execute_unit: PASSED **");
    else $display("** rv64i_integer_execute_unit: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("** rv64i_integer_execute_unit: FAILED **");
    $finish;
  end
endmodule
